### rtl/cdcw_pkg.sv
`timescale 1ns / 1ps

package cdcw_pkg;

    localparam int          YEAR_SPAN_DEF = 256;
    localparam int          MAX_YEAR      = 4095;
    localparam int          BASE_YEAR_INT = 2020;
    localparam logic [11:0] BASE_YEAR     = 12'd2020;
    localparam logic [2:0]  BASE_WEEKDAY  = 3'd2;
    // residues of the base year modulo 100 and 400
    localparam logic [6:0]  BASE_R100     = 7'd20;
    localparam logic [8:0]  BASE_R400     = 9'd20;
    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [4:0]  DAY_FIRST     = 5'd1;
    localparam logic [2:0]  WEEKDAY_SUN   = 3'd6;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SET
    } cdcw_state_t;

    typedef enum logic [1:0] {
        W_IDLE,
        W_YEAR,
        W_MONTH
    } cdcw_walk_state_t;

    typedef struct packed {
        logic       done;
        logic       date_ok;
        logic [2:0] weekday;
        logic [6:0] r100;
        logic [8:0] r400;
    } cdcw_walk_res_t;

    function automatic logic leap_of(input logic [1:0] y_lo, input logic [6:0] r100,
                                     input logic [8:0] r400);
        return ((y_lo == 2'd0) && (r100 != 7'd0)) || (r400 == 9'd0);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // days before the first of the month in a common year, modulo 7
    function automatic logic [2:0] month_off(input logic [3:0] m);
        logic [2:0] o;
        case (m)
            4'd1:    o = 3'd0;
            4'd2:    o = 3'd3;
            4'd3:    o = 3'd3;
            4'd4:    o = 3'd6;
            4'd5:    o = 3'd1;
            4'd6:    o = 3'd4;
            4'd7:    o = 3'd6;
            4'd8:    o = 3'd2;
            4'd9:    o = 3'd5;
            4'd10:   o = 3'd0;
            4'd11:   o = 3'd3;
            4'd12:   o = 3'd5;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

    // narrow value modulo 7 by compare and subtract
    function automatic logic [2:0] mod7_5b(input logic [4:0] v);
        logic [4:0] t;
        t = v;
        if (t >= 5'd28) t = t - 5'd28;
        if (t >= 5'd14) t = t - 5'd14;
        if (t >= 5'd7)  t = t - 5'd7;
        return t[2:0];
    endfunction

endpackage

### rtl/cdcw_walk.sv
`timescale 1ns / 1ps

module cdcw_walk
    import cdcw_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [4:0]     day,
    input  logic [3:0]     month,
    input  logic [11:0]    year,
    output cdcw_walk_res_t res
);

    cdcw_walk_state_t state_reg, state_next;
    logic        done_reg, done_next;
    logic        ok_reg, ok_next;
    logic [2:0]  wd_reg, wd_next;
    logic [6:0]  r100_reg, r100_next;
    logic [8:0]  r400_reg, r400_next;
    logic [11:0] wyear_reg, wyear_next;
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [11:0] year_reg;

    logic        leap;
    logic [3:0]  wd_sum;
    logic [3:0]  m_sum;
    logic [2:0]  m_red;
    logic [3:0]  d_sum;

    assign leap = leap_of(wyear_reg[1:0], r100_reg, r400_reg);

    always_comb begin
        state_next = state_reg;
        done_next  = done_reg;
        ok_next    = ok_reg;
        wd_next    = wd_reg;
        r100_next  = r100_reg;
        r400_next  = r400_reg;
        wyear_next = wyear_reg;
        wd_sum     = {1'b0, wd_reg} + (leap ? 4'd2 : 4'd1);
        m_sum      = {1'b0, wd_reg} + {1'b0, month_off(month_reg)}
                     + {3'b0, (leap && (month_reg > MONTH_FEB))};
        m_red      = (m_sum >= 4'd7) ? 3'(m_sum - 4'd7) : m_sum[2:0];
        d_sum      = {1'b0, m_red} + {1'b0, mod7_5b(day_reg - 5'd1)};
        case (state_reg)
            W_IDLE: begin
                if (start) begin
                    done_next  = 1'b0;
                    wd_next    = BASE_WEEKDAY;
                    r100_next  = BASE_R100;
                    r400_next  = BASE_R400;
                    wyear_next = BASE_YEAR;
                    state_next = W_YEAR;
                end
            end
            W_YEAR: begin
                // one year per cycle: 365 or 366 days move the weekday by 1 or 2
                if (wyear_reg == year_reg) begin
                    state_next = W_MONTH;
                end else begin
                    wd_next    = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
                    r100_next  = (r100_reg == 7'd99) ? 7'd0 : r100_reg + 7'd1;
                    r400_next  = (r400_reg == 9'd399) ? 9'd0 : r400_reg + 9'd1;
                    wyear_next = wyear_reg + 12'd1;
                end
            end
            W_MONTH: begin
                wd_next    = (d_sum >= 4'd7) ? 3'(d_sum - 4'd7) : d_sum[2:0];
                ok_next    = (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC)
                             && (day_reg >= DAY_FIRST)
                             && (day_reg <= days_in(month_reg, leap));
                done_next  = 1'b1;
                state_next = W_IDLE;
            end
            default: state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg    <= ok_next;
        wd_reg    <= wd_next;
        r100_reg  <= r100_next;
        r400_reg  <= r400_next;
        wyear_reg <= wyear_next;
        if (start && (state_reg == W_IDLE)) begin
            day_reg   <= day;
            month_reg <= month;
            year_reg  <= year;
        end
    end

    assign res.done    = done_reg;
    assign res.date_ok = ok_reg;
    assign res.weekday = wd_reg;
    assign res.r100    = r100_reg;
    assign res.r400    = r400_reg;

endmodule

### rtl/calendar_day_counter_weekday_core.sv
`timescale 1ns / 1ps

// Gregorian date and weekday counter (0 = Monday). A day tick is accepted in ST_IDLE and
// applied in ST_EXEC once the output register is free. A set request walks its year
// from 2020 one year per cycle in a modulo-7 step in cdcw_walk, then resolves month
// and day in W_MONTH and is applied in ST_SET once the output register is free. A set
// request with a year outside 2020 .. 2020 + YEAR_SPAN - 1 (capped at 4095) leaves the
// date unchanged. One transaction is in flight at a time; the next one is taken once
// the result has been placed in the output register.
module calendar_day_counter_weekday_core
    import cdcw_pkg::*;
#(
    parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [4:0]  s_set_day,
    input  logic [3:0]  s_set_month,
    input  logic [11:0] s_set_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_day_out,
    output logic [3:0]  m_month_out,
    output logic [11:0] m_year_out,
    output logic [2:0]  m_weekday_out,
    output logic        m_month_rolled,
    output logic        m_year_rolled,
    output logic        m_year_overflow
);

    localparam int          TopRaw  = BASE_YEAR_INT + YEAR_SPAN - 1;
    localparam int          TopInt  = (TopRaw > MAX_YEAR) ? MAX_YEAR : TopRaw;
    localparam logic [11:0] TopYear = 12'(TopInt);

    cdcw_state_t state_reg, state_next;
    logic        req_reg;

    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [11:0] year_reg, year_next;
    logic [2:0]  wd_reg, wd_next;
    logic [6:0]  r100_reg, r100_next;
    logic [8:0]  r400_reg, r400_next;
    logic [4:0]  sd_reg;
    logic [3:0]  sm_reg;
    logic [11:0] sy_reg;

    logic        mv_reg, mv_next;
    logic        mroll_reg, mroll_next;
    logic        yroll_reg, yroll_next;
    logic        ovf_reg, ovf_next;
    logic        load_out;

    logic           accept;
    logic           year_ok;
    logic           walk_start;
    logic           out_free;
    logic           cur_leap;
    logic [5:0]     day_inc;
    cdcw_walk_res_t walk_res;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign year_ok    = (s_set_year >= BASE_YEAR) && (s_set_year <= TopYear);
    assign walk_start = accept && (s_req_type == REQ_SET) && year_ok;
    assign out_free   = !mv_reg || m_ready;
    assign cur_leap   = leap_of(year_reg[1:0], r100_reg, r400_reg);
    assign day_inc    = {1'b0, day_reg} + 6'd1;

    cdcw_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (walk_start),
        .day     (s_set_day),
        .month   (s_set_month),
        .year    (s_set_year),
        .res     (walk_res)
    );

    always_comb begin
        state_next = state_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        wd_next    = wd_reg;
        r100_next  = r100_reg;
        r400_next  = r400_reg;
        mroll_next = 1'b0;
        yroll_next = 1'b0;
        ovf_next   = 1'b0;
        load_out   = 1'b0;
        mv_next    = mv_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = walk_start ? ST_SET : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                    // an out-of-range set leaves everything as it is
                    if (req_reg == REQ_TICK) begin
                        if ((month_reg == MONTH_DEC) && (day_reg >= 5'd31)
                            && (year_reg >= TopYear)) begin
                            ovf_next = 1'b1;
                        end else begin
                            wd_next = (wd_reg == WEEKDAY_SUN) ? 3'd0 : wd_reg + 3'd1;
                            if (day_inc > {1'b0, days_in(month_reg, cur_leap)}) begin
                                day_next   = DAY_FIRST;
                                mroll_next = 1'b1;
                                if (month_reg == MONTH_DEC) begin
                                    month_next = MONTH_JAN;
                                    year_next  = year_reg + 12'd1;
                                    r100_next  = (r100_reg == 7'd99) ? 7'd0 : r100_reg + 7'd1;
                                    r400_next  = (r400_reg == 9'd399) ? 9'd0 : r400_reg + 9'd1;
                                    yroll_next = 1'b1;
                                end else begin
                                    month_next = month_reg + 4'd1;
                                end
                            end else begin
                                day_next = day_inc[4:0];
                            end
                        end
                    end
                end
            end
            ST_SET: begin
                if (walk_res.done && out_free) begin
                    load_out   = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                    if (walk_res.date_ok) begin
                        day_next   = sd_reg;
                        month_next = sm_reg;
                        year_next  = sy_reg;
                        wd_next    = walk_res.weekday;
                        r100_next  = walk_res.r100;
                        r400_next  = walk_res.r400;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            day_reg   <= DAY_FIRST;
            month_reg <= MONTH_JAN;
            year_reg  <= BASE_YEAR;
            wd_reg    <= BASE_WEEKDAY;
            r100_reg  <= BASE_R100;
            r400_reg  <= BASE_R400;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            wd_reg    <= wd_next;
            r100_reg  <= r100_next;
            r400_reg  <= r400_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req_type;
            sd_reg  <= s_set_day;
            sm_reg  <= s_set_month;
            sy_reg  <= s_set_year;
        end
        if (load_out) begin
            m_day_out       <= {1'b0, day_next};
            m_month_out     <= month_next;
            m_year_out      <= year_next;
            m_weekday_out   <= wd_next;
            mroll_reg       <= mroll_next;
            yroll_reg       <= yroll_next;
            ovf_reg         <= ovf_next;
        end
    end

    assign m_valid         = mv_reg;
    assign m_month_rolled  = mroll_reg;
    assign m_year_rolled   = yroll_reg;
    assign m_year_overflow = ovf_reg;

endmodule
